### sv/pecl_pkg.sv
// ----------------------------------------------------------------------------
// pecl_pkg: shared types and codes for the polygon edge window clipper
// Holds command codes, register indexes, clip stage codes, window reset values,
// sequencer states and the divider status group.
// ----------------------------------------------------------------------------
package pecl_pkg;

    // Input item commands
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_CLOSE = 2'd1;

    // Configuration register indexes
    localparam logic [1:0] REG_LEFT   = 2'd0;
    localparam logic [1:0] REG_RIGHT  = 2'd1;
    localparam logic [1:0] REG_BOTTOM = 2'd2;
    localparam logic [1:0] REG_TOP    = 2'd3;

    // Clip stages, in processing order
    localparam logic [1:0] STG_LEFT   = 2'd0;
    localparam logic [1:0] STG_RIGHT  = 2'd1;
    localparam logic [1:0] STG_TOP    = 2'd2;
    localparam logic [1:0] STG_BOTTOM = 2'd3;

    // Window reset values
    localparam int WIN_RESET_LO = -100;
    localparam int WIN_RESET_HI = 100;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STAGE,
        S_MUL_A,
        S_MUL_B,
        S_DIV,
        S_PIECE,
        S_REMAIN
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

### sv/pecl_div.sv
// ----------------------------------------------------------------------------
// pecl_div: iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle, quotient
// truncated toward zero.
// ----------------------------------------------------------------------------
module pecl_div #(
    parameter int NUM_BITS = 29,
    parameter int DEN_BITS = 13
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [NUM_BITS-1:0]   num,
    input  logic signed [DEN_BITS-1:0]   den,
    output pecl_pkg::div_stat_t          stat,
    output logic signed [NUM_BITS-1:0]   quot
);
    import pecl_pkg::*;

    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [NUM_BITS-1:0]   q_reg, q_next;
    logic [DEN_BITS-1:0]   rem_reg, rem_next;
    logic [DEN_BITS-1:0]   dmag_reg, dmag_next;
    logic                  neg_reg, neg_next;
    logic [DEN_BITS:0]     trial;
    logic                  ge;
    logic [NUM_BITS-1:0]   num_mag;
    logic [DEN_BITS-1:0]   den_mag;

    // Magnitudes of the operands
    assign num_mag = num[NUM_BITS-1] ? NUM_BITS'(-num) : NUM_BITS'(num);
    assign den_mag = den[DEN_BITS-1] ? DEN_BITS'(-den) : DEN_BITS'(den);

    // One restoring step
    assign trial = {rem_reg, q_reg[NUM_BITS-1]};
    assign ge    = (trial >= {1'b0, dmag_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dmag_next = dmag_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(NUM_BITS);
            q_next    = num_mag;
            rem_next  = '0;
            dmag_next = den_mag;
            neg_next  = num[NUM_BITS-1] ^ den[DEN_BITS-1];
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DEN_BITS'(trial - {1'b0, dmag_reg}) : DEN_BITS'(trial);
            q_next   = {q_reg[NUM_BITS-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        dmag_reg <= dmag_next;
        neg_reg  <= neg_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot = neg_reg ? -$signed(q_reg) : $signed(q_reg);

endmodule

### sv/polygon_edge_window_clipper_core.sv
// Flow: an edge with no clipping passes the four stage tests and gives one item;
// each clipping stage adds two multiply steps and a run of the shared divider,
// which gives one quotient bit per cycle, up to four clipping stages per edge.
// Throughput: one input item at a time; ready only while the sequencer idles.
// Reset: asynchronous, active low; window -100..100, no polygon open.
// ----------------------------------------------------------------------------
// polygon_edge_window_clipper_core: clip polygon edges to a rectangular window
// A sequencer walks each edge through the left, right, top and bottom stages,
// sharing one multiplier and one iterative divider for the intersections.
// ----------------------------------------------------------------------------
module polygon_edge_window_clipper_core #(
    parameter int COORD_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [COORD_BITS-1:0]         cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    command,
    input  logic signed [COORD_BITS-1:0]  vertex_x,
    input  logic signed [COORD_BITS-1:0]  vertex_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_BITS-1:0]  seg_start_x,
    output logic signed [COORD_BITS-1:0]  seg_start_y,
    output logic signed [COORD_BITS-1:0]  seg_end_x,
    output logic signed [COORD_BITS-1:0]  seg_end_y,
    output logic                          is_inside,
    output logic                          last_piece
);
    import pecl_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int W  = COORD_BITS + 2;
    localparam int D  = COORD_BITS + 1;
    localparam int PW = W + 1 + D;
    localparam int NW = W + D + 2;

    state_t               state_reg, state_next;
    logic [1:0]           stg_reg, stg_next;
    logic signed [C-1:0]  wl_reg, wr_reg, wb_reg, wt_reg;
    logic signed [C-1:0]  prev_x_reg, prev_y_reg, first_x_reg, first_y_reg;
    logic                 open_reg, open_next;
    logic signed [W-1:0]  x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [W-1:0]  x1_next, y1_next, x2_next, y2_next;
    logic signed [D-1:0]  dx_reg, dy_reg;
    logic signed [NW-1:0] acc_reg, acc_next;
    logic signed [W-1:0]  p_sx_reg, p_sy_reg, p_ex_reg, p_ey_reg;
    logic signed [W-1:0]  p_sx_next, p_sy_next, p_ex_next, p_ey_next;
    logic                 ov_reg, ov_next;
    logic signed [C-1:0]  o_sx_reg, o_sy_reg, o_ex_reg, o_ey_reg;
    logic                 o_in_reg, o_last_reg;
    logic                 load_piece, load_remain, accept, edge_start;
    logic signed [C-1:0]  end_x, end_y;

    logic signed [W-1:0]  wl, wr, wb, wt;
    logic                 act, sw, clip;
    logic signed [W-1:0]  sx1, sy1, sx2, sy2;
    logic signed [W:0]    mul_a;
    logic signed [D-1:0]  mul_b;
    logic signed [PW-1:0] prod;
    logic signed [D-1:0]  den;
    logic signed [W-1:0]  keep, qw, res;
    logic                 div_start;
    div_stat_t            dstat;
    logic signed [NW-1:0] quot;
    logic                 win_inside;

    assign wl = W'(wl_reg);
    assign wr = W'(wr_reg);
    assign wb = W'(wb_reg);
    assign wt = W'(wt_reg);

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg <= C'(WIN_RESET_LO);
            wr_reg <= C'(WIN_RESET_HI);
            wb_reg <= C'(WIN_RESET_LO);
            wt_reg <= C'(WIN_RESET_HI);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LEFT:   wl_reg <= cfg_data;
                REG_RIGHT:  wr_reg <= cfg_data;
                REG_BOTTOM: wb_reg <= cfg_data;
                REG_TOP:    wt_reg <= cfg_data;
                default:    wl_reg <= wl_reg;
            endcase
        end
    end

    // Input item decode
    assign in_ready   = (state_reg == S_IDLE);
    assign accept     = in_valid && in_ready;
    assign edge_start = accept && open_reg &&
                        (command == CMD_ADD || command == CMD_CLOSE);
    assign end_x      = (command == CMD_ADD) ? vertex_x : first_x_reg;
    assign end_y      = (command == CMD_ADD) ? vertex_y : first_y_reg;

    // Stage test and end swap
    always_comb
    begin
        unique case (stg_reg)
            STG_LEFT:
            begin
                act = (x1_reg > wl) || (x2_reg > wl);
                sw  = x2_reg < x1_reg;
            end
            STG_RIGHT:
            begin
                act = (x1_reg < wr) || (x2_reg < wr);
                sw  = x1_reg > x2_reg;
            end
            STG_TOP:
            begin
                act = (y1_reg < wt) || (y2_reg < wt);
                sw  = y2_reg < y1_reg;
            end
            default:
            begin
                act = (y2_reg > wb) || (y1_reg > wb);
                sw  = y2_reg < y1_reg;
            end
        endcase
        sx1 = (act && sw) ? x2_reg : x1_reg;
        sy1 = (act && sw) ? y2_reg : y1_reg;
        sx2 = (act && sw) ? x1_reg : x2_reg;
        sy2 = (act && sw) ? y1_reg : y2_reg;
        unique case (stg_reg)
            STG_LEFT:  clip = act && (sx1 < wl);
            STG_RIGHT: clip = act && (sx2 > wr);
            STG_TOP:   clip = act && (sy2 > wt);
            default:   clip = act && (sy1 < wb);
        endcase
    end

    // Shared multiplier operands and divider setup
    always_comb
    begin
        if (state_reg == S_MUL_A)
        begin
            unique case (stg_reg)
                STG_LEFT:  begin mul_a = (W+1)'(y2_reg); mul_b = dx_reg; end
                STG_RIGHT: begin mul_a = (W+1)'(y1_reg); mul_b = dx_reg; end
                STG_TOP:   begin mul_a = (W+1)'(x1_reg); mul_b = dy_reg; end
                default:   begin mul_a = (W+1)'(x2_reg); mul_b = dy_reg; end
            endcase
        end
        else
        begin
            unique case (stg_reg)
                STG_LEFT:  begin mul_a = (W+1)'(wl) - (W+1)'(x2_reg); mul_b = dy_reg; end
                STG_RIGHT: begin mul_a = (W+1)'(wr) - (W+1)'(x1_reg); mul_b = dy_reg; end
                STG_TOP:   begin mul_a = (W+1)'(wt) - (W+1)'(y1_reg); mul_b = dx_reg; end
                default:   begin mul_a = (W+1)'(wb) - (W+1)'(y2_reg); mul_b = dx_reg; end
            endcase
        end
        unique case (stg_reg)
            STG_LEFT:  begin den = dx_reg; keep = y1_reg; end
            STG_RIGHT: begin den = dx_reg; keep = y2_reg; end
            STG_TOP:   begin den = dy_reg; keep = x2_reg; end
            default:   begin den = dy_reg; keep = x1_reg; end
        endcase
    end

    assign prod      = mul_a * mul_b;
    assign div_start = (state_reg == S_MUL_B);
    assign qw        = W'(quot);
    assign res       = (den == '0) ? keep : qw;

    pecl_div #(
        .NUM_BITS (NW),
        .DEN_BITS (D)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (acc_next),
        .den   (den),
        .stat  (dstat),
        .quot  (quot)
    );

    // Remainder inside test, bounds inclusive
    assign win_inside = (x1_reg >= wl) && (x1_reg <= wr) && (x2_reg >= wl) && (x2_reg <= wr) &&
                        (y1_reg >= wb) && (y1_reg <= wt) && (y2_reg >= wb) && (y2_reg <= wt);

    assign load_piece  = (state_reg == S_PIECE) && (!ov_reg || out_ready);
    assign load_remain = (state_reg == S_REMAIN) && (!ov_reg || out_ready);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        stg_next   = stg_reg;
        open_next  = open_reg;
        x1_next    = x1_reg;
        y1_next    = y1_reg;
        x2_next    = x2_reg;
        y2_next    = y2_reg;
        acc_next   = acc_reg;
        p_sx_next  = p_sx_reg;
        p_sy_next  = p_sy_reg;
        p_ex_next  = p_ex_reg;
        p_ey_next  = p_ey_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && command == CMD_ADD && !open_reg)
                    open_next = 1'b1;
                if (edge_start)
                begin
                    x1_next    = W'(prev_x_reg);
                    y1_next    = W'(prev_y_reg);
                    x2_next    = W'(end_x);
                    y2_next    = W'(end_y);
                    stg_next   = STG_LEFT;
                    state_next = S_STAGE;
                    if (command == CMD_CLOSE)
                        open_next = 1'b0;
                end
            end
            S_STAGE:
            begin
                x1_next = sx1;
                y1_next = sy1;
                x2_next = sx2;
                y2_next = sy2;
                if (clip)
                    state_next = S_MUL_A;
                else if (stg_reg == STG_BOTTOM)
                    state_next = S_REMAIN;
                else
                    stg_next = stg_reg + 2'd1;
            end
            S_MUL_A:
            begin
                acc_next   = NW'(prod);
                state_next = S_MUL_B;
            end
            S_MUL_B:
            begin
                acc_next   = acc_reg + NW'(prod);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (dstat.done)
                begin
                    state_next = S_PIECE;
                    unique case (stg_reg)
                        STG_LEFT:
                        begin
                            p_sx_next = x1_reg; p_sy_next = y1_reg;
                            p_ex_next = wl;     p_ey_next = res;
                            x1_next   = wl;     y1_next   = res;
                        end
                        STG_RIGHT:
                        begin
                            p_sx_next = wr;     p_sy_next = res;
                            p_ex_next = x2_reg; p_ey_next = y2_reg;
                            x2_next   = wr;     y2_next   = res;
                        end
                        STG_TOP:
                        begin
                            p_sx_next = res;    p_sy_next = wt;
                            p_ex_next = x2_reg; p_ey_next = y2_reg;
                            x2_next   = res;    y2_next   = wt;
                        end
                        default:
                        begin
                            p_sx_next = res;    p_sy_next = wb;
                            p_ex_next = x1_reg; p_ey_next = y1_reg;
                            x1_next   = res;    y1_next   = wb;
                        end
                    endcase
                end
            end
            S_PIECE:
            begin
                if (load_piece)
                begin
                    if (stg_reg == STG_BOTTOM)
                        state_next = S_REMAIN;
                    else
                    begin
                        stg_next   = stg_reg + 2'd1;
                        state_next = S_STAGE;
                    end
                end
            end
            S_REMAIN:
            begin
                if (load_remain)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Output register: drop on take, load on emit
    always_comb
    begin
        ov_next = ov_reg;
        if (out_ready)
            ov_next = 1'b0;
        if (load_piece || load_remain)
            ov_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            stg_reg     <= STG_LEFT;
            open_reg    <= 1'b0;
            ov_reg      <= 1'b0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            first_x_reg <= '0;
            first_y_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            stg_reg   <= stg_next;
            open_reg  <= open_next;
            ov_reg    <= ov_next;
            // Track previous and first vertex
            if (accept && command == CMD_ADD)
            begin
                prev_x_reg <= vertex_x;
                prev_y_reg <= vertex_y;
                if (!open_reg)
                begin
                    first_x_reg <= vertex_x;
                    first_y_reg <= vertex_y;
                end
            end
            else if (edge_start)
            begin
                prev_x_reg <= first_x_reg;
                prev_y_reg <= first_y_reg;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        x1_reg   <= x1_next;
        y1_reg   <= y1_next;
        x2_reg   <= x2_next;
        y2_reg   <= y2_next;
        acc_reg  <= acc_next;
        p_sx_reg <= p_sx_next;
        p_sy_reg <= p_sy_next;
        p_ex_reg <= p_ex_next;
        p_ey_reg <= p_ey_next;
        if (edge_start)
        begin
            dx_reg <= D'(end_x) - D'(prev_x_reg);
            dy_reg <= D'(end_y) - D'(prev_y_reg);
        end
        if (load_piece)
        begin
            o_sx_reg   <= p_sx_reg[C-1:0];
            o_sy_reg   <= p_sy_reg[C-1:0];
            o_ex_reg   <= p_ex_reg[C-1:0];
            o_ey_reg   <= p_ey_reg[C-1:0];
            o_in_reg   <= 1'b0;
            o_last_reg <= 1'b0;
        end
        else if (load_remain)
        begin
            o_sx_reg   <= x1_reg[C-1:0];
            o_sy_reg   <= y1_reg[C-1:0];
            o_ex_reg   <= x2_reg[C-1:0];
            o_ey_reg   <= y2_reg[C-1:0];
            o_in_reg   <= win_inside;
            o_last_reg <= 1'b1;
        end
    end

    assign out_valid   = ov_reg;
    assign seg_start_x = o_sx_reg;
    assign seg_start_y = o_sy_reg;
    assign seg_end_x   = o_ex_reg;
    assign seg_end_y   = o_ey_reg;
    assign is_inside   = o_in_reg;
    assign last_piece  = o_last_reg;

    // Inside marks only the remainder item
    a_inside_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_inside |-> last_piece)
        else $error("inside item not marked last");

    // Divider runs only while the sequencer waits on it
    a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        dstat.busy |-> state_reg == S_DIV)
        else $error("divider busy outside division state");

    // Emitting the remainder returns to idle
    a_remain_idle: assert property (@(posedge clk) disable iff (!rst_n)
        load_remain |=> state_reg == S_IDLE && out_valid && last_piece)
        else $error("remainder emit did not finish the edge");

endmodule
